// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is asserted
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  `ASSERT_PROP(label, (ante) |-> (cons), msg)

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_PROP(label, (ante) |=> (cons), msg)

`endif

// ===== sv/cnsp_pkg.sv =====
package cnsp_pkg;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_NAME     = 3'd1,
    PH_NAME_PAD = 3'd2,
    PH_DATA     = 3'd3,
    PH_DATA_PAD = 3'd4,
    PH_STOPPED  = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    KIND_NAME      = 3'd0,
    KIND_ENTRY     = 3'd1,
    KIND_CONTENT   = 3'd2,
    KIND_TRAILER   = 3'd3,
    KIND_BAD_MAGIC = 3'd4
  } kind_e;

  localparam logic [6:0] MagicLen    = 7'd6;
  localparam logic [6:0] HeaderLast  = 7'd109;
  localparam logic [3:0] FieldMode   = 4'd1;
  localparam logic [3:0] FieldSize   = 4'd6;
  localparam logic [3:0] FieldName   = 4'd11;
  localparam logic [3:0] TrailerLen  = 4'd10;
  localparam logic [31:0] TrailerNameSize = 32'd11;
  localparam logic [3:0] TypeRegular = 4'h8;
  localparam logic [3:0] TypeSymlink = 4'hA;

  typedef struct packed {
    phase_e      phase;
    logic [6:0]  hdr_pos;
    logic [31:0] acc;
    logic        digits_stopped;
    logic [31:0] mode;
    logic [31:0] size;
    logic [31:0] name_size;
    logic [31:0] remaining;
    logic [1:0]  align;
    logic        trailer_match;
    logic        kept;
    logic [3:0]  name_idx;
  } cnsp_state_t;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  data;
    logic        last;
    logic [31:0] mode;
    logic [31:0] size;
    logic [31:0] name_len;
    logic        kept;
  } cnsp_result_t;

  localparam cnsp_state_t StateReset = '{
    phase:          PH_HEADER,
    hdr_pos:        7'd0,
    acc:            32'd0,
    digits_stopped: 1'b0,
    mode:           32'd0,
    size:           32'd0,
    name_size:      32'd0,
    remaining:      32'd0,
    align:          2'd0,
    trailer_match:  1'b1,
    kept:           1'b0,
    name_idx:       4'd0
  };

  function automatic logic [7:0] magic_char(logic [2:0] idx);
    case (idx)
      3'd0:    magic_char = 8'h30;
      3'd1:    magic_char = 8'h37;
      3'd2:    magic_char = 8'h30;
      3'd3:    magic_char = 8'h37;
      3'd4:    magic_char = 8'h30;
      3'd5:    magic_char = 8'h31;
      default: magic_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] trailer_char(logic [3:0] idx);
    case (idx)
      4'd0:    trailer_char = 8'h54;
      4'd1:    trailer_char = 8'h52;
      4'd2:    trailer_char = 8'h41;
      4'd3:    trailer_char = 8'h49;
      4'd4:    trailer_char = 8'h4C;
      4'd5:    trailer_char = 8'h45;
      4'd6:    trailer_char = 8'h52;
      4'd7:    trailer_char = 8'h21;
      4'd8:    trailer_char = 8'h21;
      4'd9:    trailer_char = 8'h21;
      default: trailer_char = 8'h00;
    endcase
  endfunction

  // {is_digit, value}
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30;
      hex_digit = {1'b1, t[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t = c - 8'h57;
      hex_digit = {1'b1, t[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h37;
      hex_digit = {1'b1, t[3:0]};
    end else begin
      hex_digit = 5'd0;
    end
  endfunction

  function automatic cnsp_state_t begin_header(cnsp_state_t s);
    cnsp_state_t r;
    r = s;
    r.phase          = PH_HEADER;
    r.hdr_pos        = 7'd0;
    r.acc            = 32'd0;
    r.digits_stopped = 1'b0;
    r.trailer_match  = 1'b1;
    return r;
  endfunction

  function automatic cnsp_state_t enter_data_pad(cnsp_state_t s);
    cnsp_state_t r;
    r = s;
    r.align = 2'd0 - s.size[1:0];
    if (r.align != 2'd0) begin
      r.phase = PH_DATA_PAD;
    end else begin
      r = begin_header(r);
    end
    return r;
  endfunction

  function automatic cnsp_state_t enter_data(cnsp_state_t s);
    cnsp_state_t r;
    r = s;
    r.remaining = s.size;
    if (s.size != 32'd0) begin
      r.phase = PH_DATA;
    end else begin
      r = enter_data_pad(r);
    end
    return r;
  endfunction

  function automatic cnsp_state_t enter_after_name(cnsp_state_t s);
    cnsp_state_t r;
    r = s;
    r.align = 2'd2 - s.name_size[1:0];
    if (r.align != 2'd0) begin
      r.phase = PH_NAME_PAD;
    end else begin
      r = enter_data(r);
    end
    return r;
  endfunction

  function automatic cnsp_result_t make_result(kind_e kind, logic [7:0] b, logic last,
                                               cnsp_state_t s);
    cnsp_result_t r;
    r.valid    = 1'b1;
    r.kind     = kind;
    r.data     = b;
    r.last     = last;
    r.mode     = (kind != KIND_BAD_MAGIC) ? s.mode : 32'd0;
    r.size     = (kind != KIND_BAD_MAGIC) ? s.size : 32'd0;
    r.name_len = (kind != KIND_BAD_MAGIC) ? s.name_size : 32'd0;
    r.kept     = (kind != KIND_BAD_MAGIC) ? s.kept : 1'b0;
    return r;
  endfunction

endpackage

// ===== sv/cnsp_step.sv =====
module cnsp_step (
  input  logic [7:0]           byte_i,
  input  logic                 start_i,
  input  cnsp_pkg::cnsp_state_t state_i,
  output cnsp_pkg::cnsp_state_t state_o,
  output cnsp_pkg::cnsp_result_t result_o
);
  import cnsp_pkg::*;

  cnsp_state_t  s;
  cnsp_result_t res;
  logic [6:0]   rel;
  logic [3:0]   field;
  logic [2:0]   ch;
  logic [4:0]   hd;
  logic [3:0]   mtype;

  always_comb begin
    s     = start_i ? StateReset : state_i;
    res   = '0;
    rel   = s.hdr_pos - MagicLen;
    field = rel[6:3];
    ch    = rel[2:0];
    hd    = hex_digit(byte_i);
    mtype = 4'd0;
    case (s.phase)
      PH_HEADER: begin
        if (s.hdr_pos < MagicLen && byte_i != magic_char(s.hdr_pos[2:0])) begin
          res     = make_result(KIND_BAD_MAGIC, 8'd0, 1'b0, s);
          s.phase = PH_STOPPED;
        end else begin
          if (s.hdr_pos >= MagicLen) begin
            if (ch == 3'd0) begin
              s.acc            = 32'd0;
              s.digits_stopped = 1'b0;
            end
            if (!s.digits_stopped && hd[4]) begin
              s.acc = {s.acc[27:0], hd[3:0]};
            end else begin
              s.digits_stopped = 1'b1;
            end
            if (ch == 3'd7) begin
              if (field == FieldMode) begin
                s.mode = s.acc;
              end else if (field == FieldSize) begin
                s.size = s.acc;
              end else if (field == FieldName) begin
                s.name_size = s.acc;
              end
            end
          end
          if (s.hdr_pos >= HeaderLast) begin
            mtype           = s.mode[15:12];
            s.kept          = (mtype == TypeRegular) || (mtype == TypeSymlink);
            s.trailer_match = 1'b1;
            if (s.name_size == 32'd0) begin
              res = make_result(KIND_ENTRY, 8'd0, 1'b0, s);
              s   = enter_after_name(s);
            end else begin
              s.remaining = s.name_size;
              s.name_idx  = 4'd0;
              s.phase     = PH_NAME;
            end
          end else begin
            s.hdr_pos = s.hdr_pos + 7'd1;
          end
        end
      end
      PH_NAME: begin
        if (s.remaining > 32'd1) begin
          if (s.name_idx >= TrailerLen || byte_i != trailer_char(s.name_idx)) begin
            s.trailer_match = 1'b0;
          end
          res         = make_result(KIND_NAME, byte_i, s.remaining == 32'd2, s);
          s.remaining = s.remaining - 32'd1;
          if (s.name_idx < TrailerLen) begin
            s.name_idx = s.name_idx + 4'd1;
          end
        end else if (s.trailer_match && s.name_size == TrailerNameSize) begin
          res     = make_result(KIND_TRAILER, 8'd0, 1'b0, s);
          s.phase = PH_STOPPED;
        end else begin
          res = make_result(KIND_ENTRY, 8'd0, 1'b0, s);
          s   = enter_after_name(s);
        end
      end
      PH_NAME_PAD: begin
        s.align = s.align - 2'd1;
        if (s.align == 2'd0) begin
          s = enter_data(s);
        end
      end
      PH_DATA: begin
        if (s.kept) begin
          res = make_result(KIND_CONTENT, byte_i, s.remaining == 32'd1, s);
        end
        s.remaining = s.remaining - 32'd1;
        if (s.remaining == 32'd0) begin
          s = enter_data_pad(s);
        end
      end
      PH_DATA_PAD: begin
        s.align = s.align - 2'd1;
        if (s.align == 2'd0) begin
          s = begin_header(s);
        end
      end
      default: begin
      end
    endcase
    state_o  = s;
    result_o = res;
  end

endmodule

// ===== sv/cnsp_out_reg.sv =====
module cnsp_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  cnsp_pkg::cnsp_result_t result_i,
  input  logic                  out_ready_i,
  output logic                  can_load_o,
  output logic                  out_valid_o,
  output cnsp_pkg::cnsp_result_t result_o
);
  import cnsp_pkg::*;

  logic         valid_q, valid_d;
  cnsp_result_t data_q;

  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (can_load_o) begin
      valid_d = load_i && result_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && load_i && result_i.valid) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

// ===== sv/cpio_newc_stream_parser_core.sv =====
// cpio newc stream parser.
// Input channel (in_valid_i / in_ready_o) carries one archive byte per item,
// with start_archive_i set on the first byte of an archive to restart parsing.
// Output channel (out_valid_o / out_ready_i) carries at most one result per
// input byte: name bytes, an entry record, content bytes of kept entries,
// a trailer or a bad magic indication, with the entry's parsed mode, size,
// name length and kept flag alongside.
// Each byte passes an input register, the combinational parsing logic against
// the parser state, and a result register, which holds the byte's result if it
// yields one. One byte is accepted every cycle while the result register can
// load; bytes that yield no result (header, padding, dropped content) still
// pass the parsing stage, whose single state update per byte sets the rate.
// Reset empties both registers and returns the parser to the start of a
// header. While the receiver stalls, the result register holds its item;
// one more byte is taken into the input register and then in_ready_o drops
// until the result is taken. After a trailer or bad magic every byte is
// dropped until one arrives with start_archive_i set.
module cpio_newc_stream_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  archive_byte_i,
  input  logic        start_archive_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic [7:0]  data_byte_o,
  output logic        last_of_run_o,
  output logic [31:0] file_mode_o,
  output logic [31:0] file_size_o,
  output logic [31:0] name_length_o,
  output logic        entry_kept_o
);
  import cnsp_pkg::*;

  logic         s1_valid_q, s1_valid_d;
  logic [7:0]   byte_q;
  logic         start_q;
  logic         s1_fire;
  logic         can_load;
  logic         in_fire;
  cnsp_state_t  state_q, state_d;
  cnsp_result_t step_res;
  cnsp_result_t out_res;

  assign s1_fire    = s1_valid_q && can_load;
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_ready_o) begin
      s1_valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      state_q    <= StateReset;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (s1_fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q  <= archive_byte_i;
      start_q <= start_archive_i;
    end
  end

  cnsp_step u_step (
    .byte_i   (byte_q),
    .start_i  (start_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (step_res)
  );

  cnsp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_fire),
    .result_i    (step_res),
    .out_ready_i (out_ready_i),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .result_o    (out_res)
  );

  assign result_kind_o = out_res.kind;
  assign data_byte_o   = out_res.data;
  assign last_of_run_o = out_res.last;
  assign file_mode_o   = out_res.mode;
  assign file_size_o   = out_res.size;
  assign name_length_o = out_res.name_len;
  assign entry_kept_o  = out_res.kept;

`include "assert_macros.svh"

  `ASSERT_NEXT(a_stopped_silent, s1_fire && !start_q && state_q.phase == PH_STOPPED, !out_valid_o, "stopped parser produced a result")
  `ASSERT_IMPLIES(a_ready_stall, !in_ready_o, s1_valid_q && out_valid_o && !out_ready_i, "input stalled without output back-pressure")
  `ASSERT_IMPLIES(a_data_remaining, state_q.phase == PH_DATA, state_q.remaining != 32'd0, "content phase with no bytes left")
  `ASSERT_IMPLIES(a_bad_magic_clear, out_valid_o && out_res.kind == KIND_BAD_MAGIC, out_res.mode == 32'd0 && !out_res.kept, "bad magic carries entry fields")

endmodule
